// ===== design/assert_macros.svh =====
// assertion macros shared by the octree child partition files
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define OCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be true at a clock edge outside reset
`define OCP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define OCP_ASSERT(lbl, prop, msg)
`define OCP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== design/ocp_pkg.sv =====
// shared types and constants of the octree child partition block
// no dependencies
package ocp_pkg;

	localparam int KEY_LEVELS = 21;
	localparam int OCTANTS    = 8;
	localparam int OCT_W      = 3;
	localparam int KEY_W      = 63;
	localparam int ADDR_W     = 31;
	localparam int CNT_W      = 31;
	localparam int LVL_W      = 5;
	localparam int CFG_W      = 31;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 72;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = 1;
	localparam int QCNT_W     = 2;

	localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
	localparam logic [LVL_W-1:0] LEVEL_RST  = LVL_W'(1);
	localparam logic [CFG_W-1:0] LIMIT_RST  = CFG_W'(8);
	localparam logic [OCT_W-1:0] OCT_LAST   = OCT_W'(OCTANTS - 1);

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_CHILD_LEVEL = 1'b0,
		CFG_LEAF_LIMIT  = 1'b1
	} cfg_idx_t;

	// per-octant summary of one split parent
	typedef struct packed {
		logic [OCTANTS-1:0][ADDR_W-1:0] first;
		logic [OCTANTS-1:0][CNT_W-1:0]  cnt;
	} parent_rec_t;

	// saturating increment of a particle counter
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage

// ===== design/octree_child_partition.sv =====
// top level of the octree child partition block
// instantiates ocp_front, ocp_queue and ocp_back; uses ocp_pkg
//
// Takes one particle word per cycle (Morton key, address, tlast on the last particle of
// a parent) and, for every parent with more particles than leaf_limit, returns eight
// words, octants 0 to 7 in order, each with start address and count (tlast on octant 7).
// Input runs at one word per cycle; a split parent fills the output for eight words, and
// a two-entry record queue between front end and output walker lets the next parents
// stream in meanwhile. Input stalls only when a split parent closes while both queue
// entries are still draining. Results pass stage 1, the queue and the output register.
// The user must write configuration only while the block is idle; it is not enforced.

module octree_child_partition import ocp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // key[62:0], particle_address[93:63], zero pad
	input  logic                 s_tlast,   // last_particle
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // octant[2:0], empty_res[3], first_address[34:4],
	                                        // count[65:35], zero pad
	output logic                 m_tlast    // last_octant
);

	parent_rec_t rec_in;
	parent_rec_t rec_out;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_nonempty;

	// classify and accumulate
	ocp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.push      (push),
		.rec       (rec_in),
		.q_full    (q_full)
	);

	// parent record queue
	ocp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rec_in   (rec_in),
		.full     (q_full),
		.pop      (pop),
		.rec_out  (rec_out),
		.nonempty (q_nonempty)
	);

	// emit octant words
	ocp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (q_nonempty),
		.rec      (rec_out),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== design/ocp_front.sv =====
// front end: takes particle words, extracts octant digits, keeps per-octant
// first address and count, and closes each parent into a summary record; uses ocp_pkg
`include "assert_macros.svh"

module ocp_front import ocp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	output logic                 push,
	output parent_rec_t          rec,
	input  logic                 q_full
);

	logic [LVL_W-1:0]  child_level_q;
	logic [CFG_W-1:0]  leaf_limit_q;
	logic [KEY_W-1:0]  key;
	logic [LVL_W-1:0]  lev;
	logic [LVL_W-1:0]  sh;
	logic [OCT_W-1:0]  digit;

	logic              valid_s1;
	logic              last_s1;
	logic [OCT_W-1:0]  digit_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic [OCTANTS-1:0][CNT_W-1:0]  cnt_q;
	logic [OCTANTS-1:0][ADDR_W-1:0] first_q;
	logic [CNT_W-1:0]               total_q;
	logic [OCTANTS-1:0][CNT_W-1:0]  nxt_cnt;
	logic [OCTANTS-1:0][ADDR_W-1:0] nxt_first;
	logic [CNT_W-1:0]               nxt_total;
	logic close, split, stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			child_level_q <= LEVEL_RST;
			leaf_limit_q  <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHILD_LEVEL: child_level_q <= cfg_wdata[LVL_W-1:0];
				CFG_LEAF_LIMIT:  leaf_limit_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// octant digit at the child level; level zero shifts the key out
	assign key = s_tdata[KEY_W-1:0];
	always_comb begin
		lev   = (child_level_q > LVL_W'(KEY_LEVELS)) ? LVL_W'(KEY_LEVELS) : child_level_q;
		sh    = LVL_W'(KEY_LEVELS) - lev;
		digit = '0;
		for (int i = 0; i < KEY_LEVELS; i++) begin
			if (sh == LVL_W'(i)) digit = key[OCT_W*i +: OCT_W];
		end
	end

	// stage 1 word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			last_s1  <= s_tlast;
			digit_s1 <= digit;
			addr_s1  <= s_tdata[KEY_W +: ADDR_W];
		end
	end

	// octant lanes: next count and first address
	always_comb begin
		for (int j = 0; j < OCTANTS; j++) begin
			if (digit_s1 == OCT_W'(j)) begin
				nxt_cnt[j]   = sat_inc(cnt_q[j]);
				nxt_first[j] = (cnt_q[j] == '0) ? addr_s1 : first_q[j];
			end else begin
				nxt_cnt[j]   = cnt_q[j];
				nxt_first[j] = first_q[j];
			end
		end
		nxt_total = sat_inc(total_q);
	end

	// parent close and queue handshake
	assign close     = valid_s1 && last_s1;
	assign split     = nxt_total > leaf_limit_q;
	assign stall     = close && split && q_full;
	assign s_tready  = !stall;
	assign push      = close && split && !q_full;
	assign rec.first = nxt_first;
	assign rec.cnt   = nxt_cnt;

	// counters clear when a parent closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
		end else if (valid_s1 && !stall) begin
			if (close) begin
				cnt_q   <= '0;
				total_q <= '0;
			end else begin
				cnt_q   <= nxt_cnt;
				total_q <= nxt_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) first_q <= nxt_first;
	end

	`OCP_ASSERT(a_stall_only_on_close, !s_tready |-> (valid_s1 && last_s1), "front stalled off a parent close")
	`OCP_ASSERT(a_clear_after_close, (valid_s1 && last_s1 && s_tready) |=> (total_q == '0), "counters not cleared after close")

endmodule

// ===== design/ocp_queue.sv =====
// two-entry queue of parent summary records between front and back
// uses ocp_pkg
`include "assert_macros.svh"

module ocp_queue import ocp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  parent_rec_t rec_in,
	output logic        full,
	input  logic        pop,
	output parent_rec_t rec_out,
	output logic        nonempty
);

	parent_rec_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;

	assign full     = fill_q == QCNT_W'(QDEPTH);
	assign nonempty = fill_q != '0;
	assign rec_out  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QCNT_W'(1);
				2'b01:   fill_q <= fill_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

	// record storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= rec_in;
	end

	`OCP_ASSERT_NEVER(a_no_overflow, push && full, "push into full parent queue")
	`OCP_ASSERT_NEVER(a_no_underflow, pop && !nonempty, "pop from empty parent queue")

endmodule

// ===== design/ocp_back.sv =====
// back end: walks the head record octant by octant into a registered output word
// uses ocp_pkg
`include "assert_macros.svh"

module ocp_back import ocp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 nonempty,
	input  parent_rec_t          rec,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	logic [OCT_W-1:0]  oct_q;
	logic              m_tvalid_q;
	logic [OCT_W-1:0]  out_oct_q;
	logic              out_empty_q;
	logic [ADDR_W-1:0] out_first_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_last_q;
	logic              adv;
	logic              empty_sel;

	assign adv       = nonempty && (!m_tvalid_q || m_tready);
	assign pop       = adv && (oct_q == OCT_LAST);
	assign empty_sel = rec.cnt[oct_q] == '0;

	// octant walk and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				oct_q      <= oct_q + OCT_W'(1);
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (adv) begin
			out_oct_q   <= oct_q;
			out_empty_q <= empty_sel;
			out_first_q <= empty_sel ? '0 : rec.first[oct_q];
			out_cnt_q   <= rec.cnt[oct_q];
			out_last_q  <= oct_q == OCT_LAST;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(M_TDATA_W - OCT_W - 1 - ADDR_W - CNT_W)'(0),
		out_cnt_q, out_first_q, out_empty_q, out_oct_q};

	`OCP_ASSERT(a_last_on_octant7, m_tvalid_q |-> (out_last_q == (out_oct_q == OCT_LAST)), "tlast off octant seven")
	`OCP_ASSERT(a_walk_starts_at_zero, pop |=> (oct_q == '0), "octant walk not back at zero after pop")

endmodule
